// File: hdl/rcaf_pkg.sv
// Shared types and constants for the RC arming and failsafe block.
`timescale 1ns / 1ps

package rcaf_pkg;

	localparam int CHANNEL_BITS_DEF = 12;
	localparam int CMP_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int LEVEL_BITS = 12;
	localparam int IDLE_BITS = 12;
	localparam int LOSS_BITS = 16;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SWITCH_LEVEL = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_LOCK = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOST_LIMIT = 2'd2;

	localparam logic [LEVEL_BITS-1:0] SWITCH_LEVEL_RST = 12'd1700;
	localparam logic [IDLE_BITS-1:0] IDLE_LOCK_RST = 12'd3000;
	localparam logic [LOSS_BITS-1:0] LOST_LIMIT_RST = 16'd300;

	// stick thresholds in microseconds
	localparam logic [CMP_BITS-1:0] THR_LOCK_MAX = 16'd1150;
	localparam logic [CMP_BITS-1:0] YAW_LOCK_MAX = 16'd1200;
	localparam logic [CMP_BITS-1:0] THR_UNLOCK_MAX = 16'd1050;
	localparam logic [CMP_BITS-1:0] YAW_UNLOCK_HIGH = 16'd1800;
	localparam logic [CMP_BITS-1:0] YAW_RETURN_MAX = 16'd1600;
	localparam logic [CMP_BITS-1:0] THR_IDLE_MAX = 16'd1020;

	localparam logic [CMP_BITS-1:0] CH_CENTER = 16'd1500;
	localparam logic [CMP_BITS-1:0] CH_LOW = 16'd1000;
	localparam logic [CMP_BITS-1:0] THR_DESCEND = 16'd1200;

	localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;
	localparam logic [LOSS_BITS-1:0] LOSS_MAX = '1;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [1:0] {
		MODE_LOCKED = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_HEIGHT = 2'd2,
		MODE_POSITION = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		COL_OFF = 3'd0,
		COL_CYAN = 3'd1,
		COL_BLUE = 3'd2,
		COL_GREEN = 3'd3,
		COL_WHITE = 3'd4
	} colour_t;

	typedef enum logic [4:0] {
		PH_WAIT = 5'b00001,
		PH_RETURN = 5'b00010,
		PH_ARMING = 5'b00100,
		PH_ARMED = 5'b01000,
		PH_LOCKING = 5'b10000
	} phase_t;

endpackage

// File: hdl/rc_arming_and_failsafe.sv
// RC stick capture, arming state machine and link-loss failsafe.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tuser: cmd; tdata: throttle, yaw, roll, pitch, aux_one, aux_two, force_lock
// m_axis    out  tdata: flight_mode, led_colour, throttle, yaw, roll, pitch, link_lost
// cfg       in   cfg_we, cfg_index, cfg_data (no read-back)
//
// One beat per cycle sustained while the result register can advance; a taken beat sits in the
// input register, and the control step loads it into the result register that drives m_tvalid.
// Reset sets the stored sticks to throttle 1000, others 1500, aux 1000, mode locked.
// A waiting result holds while m_tready is low; the input register fills, then s_tready drops.

module rc_arming_and_failsafe #(
	parameter int CHANNEL_BITS = rcaf_pkg::CHANNEL_BITS_DEF,
	localparam int IN_BITS = ((6 * CHANNEL_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_BITS = ((4 * CHANNEL_BITS + 6 + 7) / 8) * 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// throttle_in, yaw_in, roll_in, pitch_in, aux_one_in, aux_two_in, force_lock
	input  logic [IN_BITS-1:0]                   s_tdata,
	// cmd
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// flight_mode, led_colour, throttle_out, yaw_out, roll_out, pitch_out, link_lost
	output logic [OUT_BITS-1:0]                  m_tdata,
	input  logic                                 cfg_we,
	input  logic [rcaf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [rcaf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CB = CHANNEL_BITS;
	localparam int CMPB = rcaf_pkg::CMP_BITS;

	// configuration
	logic [rcaf_pkg::LEVEL_BITS-1:0] switch_level_q;
	logic [rcaf_pkg::IDLE_BITS-1:0] idle_lock_q;
	logic [rcaf_pkg::LOSS_BITS-1:0] lost_limit_q;

	// input register
	logic valid_s1;
	logic cmd_s1;
	logic force_s1;
	logic [CB-1:0] thr_s1, yaw_s1, roll_s1, pitch_s1, aux1_s1, aux2_s1;

	// control state
	rcaf_pkg::phase_t phase_q, phase_n;
	rcaf_pkg::mode_t mode_q, mode_n;
	rcaf_pkg::colour_t colour_q, colour_n;
	logic [rcaf_pkg::IDLE_BITS-1:0] idle_q, idle_n;
	logic [rcaf_pkg::LOSS_BITS-1:0] loss_q, loss_n;
	logic [CB-1:0] thr_q, yaw_q, roll_q, pitch_q, aux1_q, aux2_q;
	logic [CB-1:0] thr_n, yaw_n, roll_n, pitch_n, aux1_n, aux2_n;
	logic lost_n;

	// result register
	logic out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;

	logic advance;

	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_level_q <= rcaf_pkg::SWITCH_LEVEL_RST;
			idle_lock_q <= rcaf_pkg::IDLE_LOCK_RST;
			lost_limit_q <= rcaf_pkg::LOST_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rcaf_pkg::CFG_SWITCH_LEVEL: begin
					switch_level_q <= cfg_data[rcaf_pkg::LEVEL_BITS-1:0];
				end
				rcaf_pkg::CFG_IDLE_LOCK: begin
					idle_lock_q <= cfg_data[rcaf_pkg::IDLE_BITS-1:0];
				end
				rcaf_pkg::CFG_LOST_LIMIT: begin
					lost_limit_q <= cfg_data[rcaf_pkg::LOSS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			thr_s1 <= s_tdata[0*CB +: CB];
			yaw_s1 <= s_tdata[1*CB +: CB];
			roll_s1 <= s_tdata[2*CB +: CB];
			pitch_s1 <= s_tdata[3*CB +: CB];
			aux1_s1 <= s_tdata[4*CB +: CB];
			aux2_s1 <= s_tdata[5*CB +: CB];
			force_s1 <= s_tdata[6*CB];
		end
	end

	// one control step on the beat held in the input register
	always_comb begin
		rcaf_pkg::phase_t ph;
		logic [CMPB-1:0] thr_c, yaw_c;

		phase_n = phase_q;
		mode_n = mode_q;
		colour_n = colour_q;
		idle_n = idle_q;
		loss_n = loss_q;
		thr_n = thr_q;
		yaw_n = yaw_q;
		roll_n = roll_q;
		pitch_n = pitch_q;
		aux1_n = aux1_q;
		aux2_n = aux2_q;
		lost_n = 1'b0;
		ph = phase_q;
		thr_c = CMPB'(thr_q);
		yaw_c = CMPB'(yaw_q);

		if (cmd_s1 == rcaf_pkg::CMD_FRAME) begin
			thr_n = thr_s1;
			yaw_n = yaw_s1;
			roll_n = roll_s1;
			pitch_n = pitch_s1;
			aux1_n = aux1_s1;
			aux2_n = aux2_s1;
			loss_n = '0;
		end else begin
			if (force_s1) begin
				mode_n = rcaf_pkg::MODE_LOCKED;
			end
			if (mode_n != rcaf_pkg::MODE_LOCKED) begin
				if (CMPB'(aux2_q) > CMPB'(switch_level_q)) begin
					mode_n = rcaf_pkg::MODE_POSITION;
				end else if (CMPB'(aux1_q) > CMPB'(switch_level_q)) begin
					mode_n = rcaf_pkg::MODE_HEIGHT;
				end else begin
					mode_n = rcaf_pkg::MODE_NORMAL;
				end
			end
			case (mode_n)
				rcaf_pkg::MODE_NORMAL: colour_n = rcaf_pkg::COL_BLUE;
				rcaf_pkg::MODE_HEIGHT: colour_n = rcaf_pkg::COL_GREEN;
				rcaf_pkg::MODE_POSITION: colour_n = rcaf_pkg::COL_WHITE;
				default: colour_n = colour_q;
			endcase

			// lock gesture overrides whatever phase we are in
			if (thr_c < rcaf_pkg::THR_LOCK_MAX && yaw_c < rcaf_pkg::YAW_LOCK_MAX) begin
				ph = rcaf_pkg::PH_LOCKING;
			end
			phase_n = ph;
			case (ph)
				rcaf_pkg::PH_WAIT: begin
					if (thr_c < rcaf_pkg::THR_UNLOCK_MAX && yaw_c > rcaf_pkg::YAW_UNLOCK_HIGH) begin
						phase_n = rcaf_pkg::PH_RETURN;
					end
				end
				rcaf_pkg::PH_RETURN: begin
					if (thr_c < rcaf_pkg::THR_UNLOCK_MAX && yaw_c < rcaf_pkg::YAW_RETURN_MAX) begin
						phase_n = rcaf_pkg::PH_ARMING;
					end
				end
				rcaf_pkg::PH_ARMING: begin
					mode_n = rcaf_pkg::MODE_NORMAL;
					phase_n = rcaf_pkg::PH_ARMED;
				end
				rcaf_pkg::PH_ARMED: begin
					if (thr_c < rcaf_pkg::THR_IDLE_MAX) begin
						if (idle_q > idle_lock_q && mode_n == rcaf_pkg::MODE_NORMAL) begin
							phase_n = rcaf_pkg::PH_LOCKING;
						end
						if (idle_q != rcaf_pkg::IDLE_MAX) begin
							idle_n = idle_q + 1'b1;
						end
					end else begin
						idle_n = '0;
					end
					if (mode_n == rcaf_pkg::MODE_LOCKED) begin
						phase_n = rcaf_pkg::PH_LOCKING;
					end
				end
				rcaf_pkg::PH_LOCKING: begin
					colour_n = rcaf_pkg::COL_CYAN;
					idle_n = '0;
					mode_n = rcaf_pkg::MODE_LOCKED;
					phase_n = rcaf_pkg::PH_WAIT;
				end
				default: begin
					phase_n = rcaf_pkg::PH_LOCKING;
				end
			endcase

			// link lost: center sticks, cut throttle, descend unless locked
			if (loss_q > lost_limit_q) begin
				lost_n = 1'b1;
				yaw_n = CB'(rcaf_pkg::CH_CENTER);
				roll_n = CB'(rcaf_pkg::CH_CENTER);
				pitch_n = CB'(rcaf_pkg::CH_CENTER);
				thr_n = CB'(rcaf_pkg::CH_LOW);
				if (mode_n != rcaf_pkg::MODE_LOCKED) begin
					thr_n = CB'(rcaf_pkg::THR_DESCEND);
					mode_n = rcaf_pkg::MODE_HEIGHT;
				end
			end
			if (loss_q != rcaf_pkg::LOSS_MAX) begin
				loss_n = loss_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rcaf_pkg::PH_WAIT;
			mode_q <= rcaf_pkg::MODE_LOCKED;
			colour_q <= rcaf_pkg::COL_OFF;
			idle_q <= '0;
			loss_q <= '0;
			thr_q <= CB'(rcaf_pkg::CH_LOW);
			yaw_q <= CB'(rcaf_pkg::CH_CENTER);
			roll_q <= CB'(rcaf_pkg::CH_CENTER);
			pitch_q <= CB'(rcaf_pkg::CH_CENTER);
			aux1_q <= CB'(rcaf_pkg::CH_LOW);
			aux2_q <= CB'(rcaf_pkg::CH_LOW);
		end else if (valid_s1 && advance) begin
			phase_q <= phase_n;
			mode_q <= mode_n;
			colour_q <= colour_n;
			idle_q <= idle_n;
			loss_q <= loss_n;
			thr_q <= thr_n;
			yaw_q <= yaw_n;
			roll_q <= roll_n;
			pitch_q <= pitch_n;
			aux1_q <= aux1_n;
			aux2_q <= aux2_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= OUT_BITS'({lost_n, pitch_n, roll_n, yaw_n, thr_n, colour_n, mode_n});
		end
	end

endmodule

// File: tb/rc_arming_and_failsafe_tb.sv
// Self-checking testbench for the RC arming and failsafe block: directed table, then random runs.
`timescale 1ns / 1ps

module rc_arming_and_failsafe_tb;
	import rcaf_pkg::*;

	localparam int CH_BITS = CHANNEL_BITS_DEF;
	localparam int IN_W = ((6 * CH_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_W = ((4 * CH_BITS + 6 + 7) / 8) * 8;

	typedef logic [CH_BITS-1:0] ch_t;

	typedef struct packed {
		logic cmd;
		ch_t throttle;
		ch_t yaw;
		ch_t roll;
		ch_t pitch;
		ch_t aux_one;
		ch_t aux_two;
		logic force_lock;
	} rc_item_t;

	typedef struct packed {
		mode_t mode;
		colour_t colour;
		ch_t throttle;
		ch_t yaw;
		ch_t roll;
		ch_t pitch;
		logic lost;
	} craft_status_t;

	// typed = 1: the status column is the answer, otherwise the predictor decides
	typedef struct packed {
		rc_item_t item;
		logic typed;
		craft_status_t status;
	} rc_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	rc_arming_and_failsafe dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predicted craft state and register copies
	phase_t craft_phase;
	mode_t craft_mode;
	colour_t led_now;
	logic [IDLE_BITS-1:0] idle_ticks;
	logic [LOSS_BITS-1:0] loss_ticks;
	ch_t thr_hold, yaw_hold, roll_hold, pitch_hold, aux_one_hold, aux_two_hold;
	logic [LEVEL_BITS-1:0] cfg_level;
	logic [IDLE_BITS-1:0] cfg_idle_lock;
	logic [LOSS_BITS-1:0] cfg_lost_limit;

	rc_row_t rc_items[$];
	craft_status_t status_due[$];
	int fault_count = 0;
	int rx_hold_cycles = 0;
	bit tx_fast = 1'b0;
	bit rx_fast = 1'b0;

	rc_row_t directed_tab [23] = '{
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b1,
			'{MODE_LOCKED, COL_OFF, 12'd1000, 12'd1500, 12'd1500, 12'd1500, 1'b0}},
		'{'{CMD_FRAME, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1},
			1'b1, '{MODE_LOCKED, COL_OFF, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0}},
		'{'{CMD_TICK, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0},
			1'b0, '0},
		'{'{CMD_FRAME, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b1,
			'{MODE_LOCKED, COL_OFF, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}},
		// forced lock with both sticks low: locking runs at once and lights cyan
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b1,
			'{MODE_LOCKED, COL_CYAN, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}},
		'{'{CMD_FRAME, 12'd1000, 12'd2000, 12'd1500, 12'd1500, 12'd1000, 12'd1000, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_FRAME, 12'd1000, 12'd1500, 12'd1500, 12'd1500, 12'd1000, 12'd1000, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		// aux exactly at the level is off, one above is on
		'{'{CMD_FRAME, 12'd1100, 12'd1500, 12'd1500, 12'd1500, 12'd1701, 12'd1700, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_FRAME, 12'd1100, 12'd1500, 12'd1500, 12'd1500, 12'd1701, 12'd1701, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_FRAME, 12'd1019, 12'd1500, 12'd1500, 12'd1500, 12'd1000, 12'd1000, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b1}, 1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_FRAME, 12'd1149, 12'd1199, 12'd1500, 12'd1500, 12'd1000, 12'd1000, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0},
		'{'{CMD_FRAME, 12'd1050, 12'd1801, 12'd1500, 12'd1500, 12'd1000, 12'd1000, 1'b0},
			1'b0, '0},
		'{'{CMD_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0}, 1'b0, '0}
	};

	task automatic reset_craft();
		craft_phase = PH_WAIT;
		craft_mode = MODE_LOCKED;
		led_now = COL_OFF;
		idle_ticks = '0;
		loss_ticks = '0;
		thr_hold = ch_t'(CH_LOW);
		yaw_hold = ch_t'(CH_CENTER);
		roll_hold = ch_t'(CH_CENTER);
		pitch_hold = ch_t'(CH_CENTER);
		aux_one_hold = ch_t'(CH_LOW);
		aux_two_hold = ch_t'(CH_LOW);
		cfg_level = SWITCH_LEVEL_RST;
		cfg_idle_lock = IDLE_LOCK_RST;
		cfg_lost_limit = LOST_LIMIT_RST;
	endtask

	task automatic run_arm_gestures();
		if (thr_hold < THR_LOCK_MAX && yaw_hold < YAW_LOCK_MAX)
			craft_phase = PH_LOCKING;
		case (craft_phase)
			PH_WAIT: begin
				if (thr_hold < THR_UNLOCK_MAX && yaw_hold > YAW_UNLOCK_HIGH)
					craft_phase = PH_RETURN;
			end
			PH_RETURN: begin
				if (thr_hold < THR_UNLOCK_MAX && yaw_hold < YAW_RETURN_MAX)
					craft_phase = PH_ARMING;
			end
			PH_ARMING: begin
				craft_mode = MODE_NORMAL;
				craft_phase = PH_ARMED;
			end
			PH_ARMED: begin
				if (thr_hold < THR_IDLE_MAX) begin
					if (idle_ticks > cfg_idle_lock && craft_mode == MODE_NORMAL)
						craft_phase = PH_LOCKING;
					if (idle_ticks != IDLE_MAX)
						idle_ticks++;
				end else begin
					idle_ticks = '0;
				end
				if (craft_mode == MODE_LOCKED)
					craft_phase = PH_LOCKING;
			end
			PH_LOCKING: begin
				led_now = COL_CYAN;
				idle_ticks = '0;
				craft_mode = MODE_LOCKED;
				craft_phase = PH_WAIT;
			end
			default: craft_phase = PH_LOCKING;
		endcase
	endtask

	task automatic rc_step(input rc_item_t it, output craft_status_t st);
		logic lost;
		lost = 1'b0;
		if (it.cmd == CMD_FRAME) begin
			thr_hold = it.throttle;
			yaw_hold = it.yaw;
			roll_hold = it.roll;
			pitch_hold = it.pitch;
			aux_one_hold = it.aux_one;
			aux_two_hold = it.aux_two;
			loss_ticks = '0;
		end else begin
			if (it.force_lock)
				craft_mode = MODE_LOCKED;
			if (craft_mode != MODE_LOCKED) begin
				if (aux_two_hold > cfg_level)
					craft_mode = MODE_POSITION;
				else if (aux_one_hold > cfg_level)
					craft_mode = MODE_HEIGHT;
				else
					craft_mode = MODE_NORMAL;
			end
			case (craft_mode)
				MODE_NORMAL: led_now = COL_BLUE;
				MODE_HEIGHT: led_now = COL_GREEN;
				MODE_POSITION: led_now = COL_WHITE;
				default: ;
			endcase
			run_arm_gestures();
			// link lost: center the sticks, descend in height hold unless locked
			if (loss_ticks > cfg_lost_limit) begin
				lost = 1'b1;
				yaw_hold = ch_t'(CH_CENTER);
				roll_hold = ch_t'(CH_CENTER);
				pitch_hold = ch_t'(CH_CENTER);
				thr_hold = ch_t'(CH_LOW);
				if (craft_mode != MODE_LOCKED) begin
					thr_hold = ch_t'(THR_DESCEND);
					craft_mode = MODE_HEIGHT;
				end
			end
			if (loss_ticks != LOSS_MAX)
				loss_ticks++;
		end
		st = '{craft_mode, led_now, thr_hold, yaw_hold, roll_hold, pitch_hold, lost};
	endtask

	function automatic ch_t pick_stick();
		int lim;
		case ($urandom_range(0, 7))
			0: return ch_t'($urandom);
			1, 2: begin
				case ($urandom_range(0, 5))
					0: lim = THR_LOCK_MAX;
					1: lim = YAW_LOCK_MAX;
					2: lim = THR_UNLOCK_MAX;
					3: lim = YAW_UNLOCK_HIGH;
					4: lim = YAW_RETURN_MAX;
					default: lim = THR_IDLE_MAX;
				endcase
				return ch_t'(lim + $urandom_range(0, 2) - 1);
			end
			default: return ch_t'($urandom_range(1000, 2000));
		endcase
	endfunction

	function automatic ch_t pick_aux();
		case ($urandom_range(0, 4))
			0: return ch_t'($urandom);
			1: return ch_t'(cfg_level + $urandom_range(0, 2) - 1);
			2: return ch_t'($urandom_range(900, 1300));
			default: return ch_t'($urandom_range(1750, 2100));
		endcase
	endfunction

	task automatic queue_frame(input ch_t thr, input ch_t yaw, input ch_t roll, input ch_t pitch,
			input ch_t aux_one, input ch_t aux_two);
		rc_row_t row;
		row = '0;
		row.item = '{CMD_FRAME, thr, yaw, roll, pitch, aux_one, aux_two, 1'($urandom)};
		rc_items.push_back(row);
	endtask

	// stick fields of a tick carry junk; the block must ignore them
	task automatic queue_tick(input logic force_lock);
		rc_row_t row;
		row = '0;
		row.item = '{CMD_TICK, ch_t'($urandom), ch_t'($urandom), ch_t'($urandom),
			ch_t'($urandom), ch_t'($urandom), ch_t'($urandom), force_lock};
		rc_items.push_back(row);
	endtask

	task automatic queue_random(input int count);
		rc_row_t row;
		while (rc_items.size() < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					queue_frame(ch_t'($urandom_range(900, 1049)), ch_t'($urandom_range(1801, 2100)),
						pick_stick(), pick_stick(), pick_aux(), pick_aux());
					queue_tick(1'b0);
					// drop the stick return now and then
					if ($urandom_range(0, 4) != 0)
						queue_frame(ch_t'($urandom_range(900, 1049)),
							ch_t'($urandom_range(1200, 1599)),
							pick_stick(), pick_stick(), pick_aux(), pick_aux());
					queue_tick(1'b0);
					queue_tick(1'b0);
				end
				2, 3, 4: begin
					queue_frame(($urandom_range(0, 2) == 0) ? pick_stick() :
						ch_t'($urandom_range(1020, 1900)),
						pick_stick(), pick_stick(), pick_stick(), pick_aux(), pick_aux());
					repeat ($urandom_range(1, 5)) queue_tick(1'b0);
				end
				5: begin
					queue_frame(ch_t'($urandom_range(900, 1149)), ch_t'($urandom_range(800, 1199)),
						pick_stick(), pick_stick(), pick_aux(), pick_aux());
					queue_tick(1'b0);
					queue_tick(1'b0);
				end
				6: queue_tick(1'b1);
				7: repeat ($urandom_range(1, 40)) queue_tick($urandom_range(0, 19) == 0);
				8: begin
					queue_frame(ch_t'($urandom_range(900, 1019)), ch_t'($urandom_range(1200, 1800)),
						pick_stick(), pick_stick(), pick_aux(), pick_aux());
					repeat ($urandom_range(1, 30)) queue_tick(1'b0);
				end
				default: begin
					row = '0;
					row.item = rc_item_t'({$urandom, $urandom, $urandom});
					rc_items.push_back(row);
				end
			endcase
		end
	endtask

	task automatic set_config(input logic [CFG_DATA_BITS-1:0] level,
			input logic [CFG_DATA_BITS-1:0] idle_lock, input logic [CFG_DATA_BITS-1:0] lost_limit);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SWITCH_LEVEL;
		cfg_data <= level;
		@(posedge clk);
		cfg_index <= CFG_IDLE_LOCK;
		cfg_data <= idle_lock;
		@(posedge clk);
		cfg_index <= CFG_LOST_LIMIT;
		cfg_data <= lost_limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_level = level[LEVEL_BITS-1:0];
		cfg_idle_lock = idle_lock[IDLE_BITS-1:0];
		cfg_lost_limit = lost_limit[LOSS_BITS-1:0];
	endtask

	task automatic play_items();
		rc_row_t row;
		craft_status_t st;
		int burst;
		int gap;
		while (rc_items.size() != 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && rc_items.size() != 0) begin
				row = rc_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= row.item.cmd;
				s_tdata <= IN_W'({row.item.force_lock, row.item.aux_two, row.item.aux_one,
					row.item.pitch, row.item.roll, row.item.yaw, row.item.throttle});
				@(posedge clk);
				while (!s_tready) @(posedge clk);
				rc_step(row.item, st);
				status_due.push_back(row.typed ? row.status : st);
				burst--;
			end
			if (tx_fast || $urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 7);
			if (gap > 0 || rc_items.size() == 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		int waited;
		waited = 0;
		while (status_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (status_due.size() != 0) begin
			if (fault_count < 10)
				$display("missing: %0d expected status beats never arrived", status_due.size());
			fault_count += status_due.size();
			status_due.delete();
		end
	endtask

	always @(posedge clk) begin
		craft_status_t got;
		craft_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.mode = mode_t'(m_tdata[1:0]);
			got.colour = colour_t'(m_tdata[4:2]);
			got.throttle = m_tdata[5 +: CH_BITS];
			got.yaw = m_tdata[5 + CH_BITS +: CH_BITS];
			got.roll = m_tdata[5 + 2 * CH_BITS +: CH_BITS];
			got.pitch = m_tdata[5 + 3 * CH_BITS +: CH_BITS];
			got.lost = m_tdata[5 + 4 * CH_BITS];
			if (status_due.size() == 0) begin
				if (fault_count < 10)
					$display("%0t: unexpected status beat mode %0d", $realtime, got.mode);
				fault_count++;
			end else begin
				want = status_due.pop_front();
				if (got !== want) begin
					if (fault_count < 10)
						$display({"%0t: mismatch exp mode %0d led %0d thr %0d yaw %0d roll %0d ",
							"pitch %0d lost %0d, got %0d %0d %0d %0d %0d %0d %0d"}, $realtime,
							want.mode, want.colour, want.throttle, want.yaw, want.roll,
							want.pitch, want.lost, got.mode, got.colour, got.throttle,
							got.yaw, got.roll, got.pitch, got.lost);
					fault_count++;
				end
			end
		end
	end

	// output side pacing: stretches with their own stall rate, plus a long hold-off on request
	initial begin : rx_pace
		int stretch;
		int stall_pct;
		m_tready <= 1'b0;
		forever begin
			stretch = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			repeat (stretch) begin
				@(posedge clk);
				if (rx_hold_cycles > 0) begin
					m_tready <= 1'b0;
					repeat (rx_hold_cycles) @(posedge clk);
					rx_hold_cycles = 0;
				end
				m_tready <= rx_fast || ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("rc_arming_and_failsafe_tb: done, errors");
		$finish;
	end

	initial begin : run
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_FRAME;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SWITCH_LEVEL;
		cfg_data <= '0;
		reset_craft();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_tab[k])
			rc_items.push_back(directed_tab[k]);
		play_items();
		drain_results();

		queue_random(300);
		play_items();
		drain_results();

		set_config('0, '0, '0);
		queue_random(300);
		play_items();
		drain_results();

		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_random(250);
		play_items();
		drain_results();

		for (int k = 0; k < 2; k++) begin
			set_config({4'($urandom), 12'($urandom_range(1500, 1900))},
				{4'($urandom), 12'($urandom_range(0, 20))}, 16'($urandom_range(0, 30)));
			queue_random(200);
			// stall the output long enough that the input backs up
			if (k == 0)
				rx_hold_cycles = 300;
			play_items();
			drain_results();
		end

		// idle auto-lock: arm, then sit at idle throttle in normal mode past a short idle limit
		tx_fast = 1'b1;
		rx_fast = 1'b1;
		set_config(16'd1700, 16'd10, 16'hFFFF);
		queue_frame(12'd1000, 12'd1000, 12'd1500, 12'd1500, 12'd1000, 12'd1000);
		queue_tick(1'b0);
		queue_tick(1'b0);
		queue_frame(12'd1000, 12'd2000, 12'd1500, 12'd1500, 12'd1000, 12'd1000);
		queue_tick(1'b0);
		queue_frame(12'd1000, 12'd1500, 12'd1500, 12'd1500, 12'd1000, 12'd1000);
		queue_tick(1'b0);
		queue_tick(1'b0);
		repeat (20) queue_tick(1'b0);
		play_items();
		drain_results();

		if (fault_count == 0)
			$display("rc_arming_and_failsafe_tb: done, clean");
		else
			$display("rc_arming_and_failsafe_tb: done, errors");
		$finish;
	end

endmodule
